// File: design/pcbs_pkg.sv
// ============================================================================
// pcbs_pkg - shared types and constants for per-class box suppression
// Field widths, packed word layouts and the sequencer state encoding.
// ============================================================================
package pcbs_pkg;

    localparam int MaxBoxesDefault   = 64;
    localparam int ClassCountDefault = 7;
    localparam int CoordW            = 16;
    localparam int ConfW             = 16;
    localparam int CatW              = 3;
    localparam int BoxW              = 4 * CoordW + 2 * ConfW + CatW;
    localparam int ThrW              = 16;
    localparam logic [ThrW-1:0] ThrReset = 16'd39322;
    localparam int InDataW           = 104;
    localparam int OutDataW          = 104;

    // Stored box: corners, confidences, category.
    typedef struct packed {
        logic [CatW-1:0]          category;
        logic [ConfW-1:0]         class_conf;
        logic [ConfW-1:0]         object_conf;
        logic signed [CoordW-1:0] bottom;
        logic signed [CoordW-1:0] right;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] left;
    } t_box;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_RANK  = 6'b000010,
        ST_RPICK = 6'b000100,
        ST_SUPP  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_WAIT  = 6'b100000
    } t_state;

endpackage

// File: design/pcbs_iou.sv
// ============================================================================
// pcbs_iou - pipelined overlap test
// Four stages: overlap and box widths, intersection and area products, union, threshold compare.
// ============================================================================
module pcbs_iou (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pcbs_pkg::t_box      i_a,
    input  pcbs_pkg::t_box      i_b,
    input  logic [15:0]         i_threshold,
    output logic                o_valid,
    output logic                o_suppress
);
    import pcbs_pkg::*;

    logic [3:0]         r_vld;
    logic signed [17:0] r_w, r_h, r_aw, r_ah, r_bw, r_bh;
    logic signed [35:0] r_inter, r_area_a, r_area_b;
    logic signed [37:0] r_union;
    logic signed [35:0] r_inter2;
    logic               r_supp;

    logic signed [16:0] n_x1, n_y1, n_x2, n_y2, n_dw, n_dh;

    always_comb begin
        n_x1 = (i_a.left  > i_b.left)   ? 17'(i_a.left)   : 17'(i_b.left);
        n_y1 = (i_a.top   > i_b.top)    ? 17'(i_a.top)    : 17'(i_b.top);
        n_x2 = (i_a.right < i_b.right)  ? 17'(i_a.right)  : 17'(i_b.right);
        n_y2 = (i_a.bottom < i_b.bottom) ? 17'(i_a.bottom) : 17'(i_b.bottom);
        n_dw = n_x2 - n_x1;
        n_dh = n_y2 - n_y1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
        r_w  <= (n_dw > 0) ? 18'(n_dw) : '0;
        r_h  <= (n_dh > 0) ? 18'(n_dh) : '0;
        r_aw <= 18'(i_a.right) - 18'(i_a.left);
        r_ah <= 18'(i_a.bottom) - 18'(i_a.top);
        r_bw <= 18'(i_b.right) - 18'(i_b.left);
        r_bh <= 18'(i_b.bottom) - 18'(i_b.top);
        r_inter  <= r_w * r_h;
        r_area_a <= r_aw * r_ah;
        r_area_b <= r_bw * r_bh;
        r_union  <= 38'(r_area_a) + 38'(r_area_b) - 38'(r_inter);
        r_inter2 <= r_inter;
        // inter * 2^16 > thr * union, only when union positive
        r_supp <= (r_union > 0) &&
                  ({4'b0, r_inter2, 16'b0} >
                   (56'(unsigned'(r_union)) * 56'(i_threshold)));
    end

    assign o_valid    = r_vld[3];
    assign o_suppress = r_supp;

endmodule

// File: design/per_class_box_suppression.sv
// ============================================================================
// per_class_box_suppression - greedy per-class IoU box suppression
// Loads boxes into memory, ranks by score, suppresses, streams kept boxes.
// ============================================================================
// Candidates are taken one per cycle into a box memory until one carries
// final_box. Ranking then runs a selection pass: for each of the n ranks the
// memory is scanned once and a pick state writes the winner to the rank list
// memory. Suppression compares each ranked box against earlier kept boxes
// through a 4-stage overlap pipeline, one pair at a time; only same-class
// pairs enter the pipeline. The emit pass visits every rank in turn, so kept
// boxes leave one at a time and wait while the output stalls. Input is not
// taken while ranking, suppression and emission run. The overlap threshold
// register is written on its own port.
module per_class_box_suppression #(
    parameter int MAX_BOXES   = pcbs_pkg::MaxBoxesDefault,
    parameter int CLASS_COUNT = pcbs_pkg::ClassCountDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: left, top, right, bottom, object_confidence, class_confidence,
    //        category, zero fill
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pcbs_pkg::InDataW-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,   // final_box
    // tdata: kept_left, kept_top, kept_right, kept_bottom,
    //        kept_object_confidence, kept_class_confidence, kept_category, fill
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pcbs_pkg::OutDataW-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,   // last_kept
    output logic                          m_axis_tuser,   // overflowed
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcbs_pkg::ThrW-1:0]     i_cfg_data
);
    import pcbs_pkg::*;

    localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    // room for the scan counter to reach count + 1
    localparam int CntW = $clog2(MAX_BOXES + 2);

    // memories
    t_box            box_mem [MAX_BOXES];
    logic [IdxW-1:0] ord_mem [MAX_BOXES];
    logic            keep_mem[MAX_BOXES];

    t_state           r_state;
    logic [ThrW-1:0]  r_thr;
    logic [CntW-1:0]  r_cnt;
    logic             r_ovf;
    logic [MAX_BOXES-1:0] r_taken;
    logic [CntW-1:0]  r_rank, r_scan, r_j;
    logic             r_found;
    logic [31:0]      r_best_score;
    logic [IdxW-1:0]  r_best;
    logic             r_rd_vld;
    logic [IdxW-1:0]  r_rd_idx;
    t_box             r_rd_box;
    t_box             r_cur;
    logic [IdxW-1:0]  r_cur_idx;
    logic             r_keep;
    logic [2:0]       r_ph;
    logic [IdxW-1:0]  r_ord_q;
    logic             r_keep_q;
    t_box             r_other;
    logic             r_iou_go;
    logic [IdxW-1:0]  r_last_idx;
    logic             r_out_vld;
    t_box             r_out_box;
    logic             r_out_last;
    logic             r_out_ovf;

    logic             iou_vld, iou_supp;
    logic             load_fire;
    logic [31:0]      rd_score;
    t_box             in_box;
    logic             pair_go;
    logic             out_load;
    logic [CntW-1:0]  j_inc;

    assign in_box = t_box'(s_axis_tdata[BoxW-1:0]);
    assign s_axis_tready = (r_state == ST_LOAD);
    assign load_fire     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign rd_score      = r_rd_box.object_conf * r_rd_box.class_conf;
    assign j_inc         = r_j + 1'b1;

    assign pair_go  = (r_state == ST_SUPP) && (r_ph == 3'd3) && r_keep_q &&
                      (r_rd_box.category == r_cur.category);
    assign out_load = (r_state == ST_EMIT) && (r_ph == 3'd2) &&
                      (!r_out_vld || m_axis_tready) && r_keep_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrReset;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    pcbs_iou u_iou (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_iou_go),
        .i_a        (r_other),
        .i_b        (r_cur),
        .i_threshold(r_thr),
        .o_valid    (iou_vld),
        .o_suppress (iou_supp)
    );

    // memory reads, registered
    logic [IdxW-1:0] box_raddr, ord_raddr;
    logic            box_we, ord_we, keep_we;
    logic [IdxW-1:0] box_waddr, ord_waddr, keep_waddr;
    logic            keep_wdata;

    always_ff @(posedge i_clk) begin
        if (box_we) box_mem[box_waddr] <= in_box;
        if (ord_we) ord_mem[ord_waddr] <= r_best;
        if (keep_we) keep_mem[keep_waddr] <= keep_wdata;
        r_rd_box <= box_mem[box_raddr];
        r_ord_q  <= ord_mem[ord_raddr];
        r_keep_q <= keep_mem[box_raddr];
    end

    assign box_we    = load_fire && (r_cnt < CntW'(MAX_BOXES));
    assign box_waddr = r_cnt[IdxW-1:0];
    assign ord_we    = (r_state == ST_RPICK);
    assign ord_waddr = r_rank[IdxW-1:0];

    // sequencer; the same phase counter drives read address selection
    always_comb begin
        box_raddr = r_scan[IdxW-1:0];
        ord_raddr = r_j[IdxW-1:0];
        case (r_state)
            ST_SUPP: begin
                box_raddr = (r_ph == 3'd1 || r_ph == 3'd2) ? r_ord_q : r_cur_idx;
                // fetch the next rank entry ahead of the next pair
                if (r_ph == 3'd5) ord_raddr = j_inc[IdxW-1:0];
            end
            ST_EMIT: begin
                box_raddr = r_ord_q;
            end
            default: begin
                box_raddr = r_scan[IdxW-1:0];
            end
        endcase
    end

    assign keep_we    = (r_state == ST_SUPP) && (r_ph == 3'd6);
    assign keep_waddr = r_cur_idx;
    assign keep_wdata = r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
            r_iou_go  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_ph      <= '0;
        end else begin
            r_iou_go <= pair_go;
            if (out_load) r_out_vld <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_vld <= 1'b0;
            case (r_state)
                ST_LOAD: begin
                    if (load_fire) begin
                        if (r_cnt < CntW'(MAX_BOXES)) r_cnt <= r_cnt + 1'b1;
                        else r_ovf <= 1'b1;
                        if (s_axis_tlast) begin
                            r_state <= ST_RANK;
                            r_taken <= '0;
                            r_rank  <= '0;
                            r_scan  <= '0;
                            r_found <= 1'b0;
                            r_rd_vld <= 1'b0;
                        end
                    end
                end
                ST_RANK: begin
                    // address r_scan issued; data arrives next cycle
                    r_rd_vld <= (r_scan < r_cnt);
                    r_rd_idx <= r_scan[IdxW-1:0];
                    if (r_scan <= r_cnt) r_scan <= r_scan + 1'b1;
                    if (r_rd_vld && !r_taken[r_rd_idx] &&
                        (!r_found || rd_score > r_best_score)) begin
                        r_found      <= 1'b1;
                        r_best       <= r_rd_idx;
                        r_best_score <= rd_score;
                    end
                    if (r_scan == r_cnt + 1'b1) r_state <= ST_RPICK;
                end
                ST_RPICK: begin
                    r_taken[r_best] <= 1'b1;
                    r_found  <= 1'b0;
                    r_scan   <= '0;
                    r_rd_vld <= 1'b0;
                    if (r_rank + 1'b1 == r_cnt) begin
                        r_state <= ST_SUPP;
                        r_rank  <= '0;
                        r_j     <= '0;
                        r_ph    <= '0;
                    end else begin
                        r_rank  <= r_rank + 1'b1;
                        r_state <= ST_RANK;
                    end
                end
                ST_SUPP: begin
                    // ph0: ord[j=rank] read, ph1: idx latched, read box
                    // ph7: cur box in, read ord[j] for earlier ranks; ph2: read other box
                    // ph3: other box in, fire pair if kept and same class; ph4: wait result
                    // ph5: next earlier rank or done; ph6: write keep mark
                    case (r_ph)
                        3'd0: begin
                            r_j  <= r_rank;
                            r_ph <= 3'd1;
                        end
                        3'd1: begin
                            r_cur_idx <= r_ord_q;
                            r_j  <= '0;
                            r_keep <= 1'b1;
                            r_ph <= 3'd7;
                        end
                        3'd7: begin
                            r_cur <= r_rd_box;
                            r_ph  <= (r_rank == '0) ? 3'd6 : 3'd2;
                        end
                        3'd2: begin
                            r_ph <= 3'd3;
                        end
                        3'd3: begin
                            r_other <= r_rd_box;
                            r_ph    <= pair_go ? 3'd4 : 3'd5;
                        end
                        3'd4: begin
                            if (iou_vld) begin
                                if (iou_supp) r_keep <= 1'b0;
                                r_ph <= 3'd5;
                            end
                        end
                        3'd5: begin
                            if (!r_keep || r_j + 1'b1 == r_rank) begin
                                r_ph <= 3'd6;
                            end else begin
                                r_j  <= r_j + 1'b1;
                                r_ph <= 3'd2;
                            end
                        end
                        default: begin
                            // ph6: mark written this cycle
                            if (r_keep) r_last_idx <= r_rank[IdxW-1:0];
                            if (r_rank + 1'b1 == r_cnt) begin
                                r_state <= ST_EMIT;
                                r_j     <= '0;
                                r_ph    <= '0;
                            end else begin
                                r_rank <= r_rank + 1'b1;
                                r_j    <= r_rank + 1'b1;
                                r_ph   <= 3'd0;
                            end
                        end
                    endcase
                end
                ST_EMIT: begin
                    // ph0: ord[j] read; ph1: box and keep read; ph2: out
                    case (r_ph)
                        3'd0: r_ph <= 3'd1;
                        3'd1: r_ph <= 3'd2;
                        default: begin
                            if (!r_out_vld || m_axis_tready) begin
                                if (r_keep_q) begin
                                    r_out_box  <= r_rd_box;
                                    r_out_last <= (r_j[IdxW-1:0] == r_last_idx);
                                    r_out_ovf  <= r_ovf;
                                end
                                if (r_j + 1'b1 == r_cnt) begin
                                    r_state <= ST_WAIT;
                                end else begin
                                    r_j  <= r_j + 1'b1;
                                    r_ph <= 3'd0;
                                end
                            end
                        end
                    endcase
                end
                ST_WAIT: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_state <= ST_LOAD;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OutDataW - BoxW){1'b0}}, r_out_box};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

`ifndef SYNTHESIS
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MAX_BOXES))
        else $error("count beyond capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
`endif

endmodule
